// ===== rtl/trsc_pkg.sv =====
// ----------------------------------------------------------------------------
// trsc_pkg: shared definitions for the three-rotor substitution cipher
// Item field widths, rotor geometry, ASCII bounds, a modulo-26 helper and letter tests.
// ----------------------------------------------------------------------------
`default_nettype none

package trsc_pkg;

  // Rotor geometry
  localparam int unsigned NUM_ROTORS = 3;
  localparam int unsigned ALPHA_LEN  = 26;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [POS_W-1:0] LAST_COUNT = POS_W'(ALPHA_LEN - 1);
  localparam logic [POS_W:0]   ALPHA_MOD  = (POS_W+1)'(ALPHA_LEN);

  // ASCII letter bounds
  localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z_LOWER = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_A_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z_UPPER = 8'h5A;

  // Item kinds
  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_CHAR = 1'b1
  } mode_e;

  typedef logic [POS_W-1:0]  sym_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Reduce a value below twice the alphabet length into 0..25
  function automatic sym_t mod_alpha(input logic [POS_W:0] s);
    logic [POS_W:0] r;
    r = (s >= ALPHA_MOD) ? (s - ALPHA_MOD) : s;
    return r[POS_W-1:0];
  endfunction

  function automatic logic is_lower(input char_t c);
    return (c >= CHAR_A_LOWER) && (c <= CHAR_Z_LOWER);
  endfunction

  function automatic logic is_upper(input char_t c);
    return (c >= CHAR_A_UPPER) && (c <= CHAR_Z_UPPER);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trsc_in_if.sv =====
// ----------------------------------------------------------------------------
// trsc_in_if: input item channel
// Valid/ready channel carrying one load or character item.
// ----------------------------------------------------------------------------
`default_nettype none

interface trsc_in_if;
  logic                              valid;
  logic                              ready;
  trsc_pkg::mode_e                   mode;
  logic [trsc_pkg::SEL_W-1:0]        rotor_sel;
  logic [trsc_pkg::POS_W-1:0]        position;
  logic [trsc_pkg::POS_W-1:0]        entry_value;
  logic [trsc_pkg::CHAR_W-1:0]       char_in;

  modport source (output valid, mode, rotor_sel, position, entry_value, char_in,
                  input ready);
  modport sink   (input valid, mode, rotor_sel, position, entry_value, char_in,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/trsc_out_if.sv =====
// ----------------------------------------------------------------------------
// trsc_out_if: result item channel
// Valid/ready channel carrying one output byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface trsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [trsc_pkg::CHAR_W-1:0] char_out;

  modport source (output valid, char_out, input ready);
  modport sink   (input valid, char_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/three_rotor_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher: odometer-stepped three-rotor cipher
// Loads rotor tables entry by entry and substitutes letters through the
// rotor chain; other bytes pass through unchanged.
// ----------------------------------------------------------------------------
//  Channel   Dir  Modport  Payload
//  item_i    in   sink     mode, rotor_sel, position, entry_value, char_in
//  result_o  out  source   char_out
//
//  One item per cycle unless a character meets a stalled result. A character
//  passes the input register, then the result register; the limit is the
//  chained lookup through the three rotor tables and offset adds between them.
//  Reset clears valid flags and offsets; rotor tables hold garbage until loaded.
//  A stalled result holds the result register; the input register still drains
//  load items, and accepts a new item as soon as its current one moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module three_rotor_substitution_cipher (
  input  wire          clk_i,
  input  wire          rst_ni,
  trsc_in_if.sink      item_i,
  trsc_out_if.source   result_o
);

  localparam int unsigned NR = trsc_pkg::NUM_ROTORS;

  // Input register
  logic                         in_valid_q;
  trsc_pkg::mode_e              in_mode_q;
  logic [trsc_pkg::SEL_W-1:0]   in_sel_q;
  trsc_pkg::sym_t               in_pos_q;
  trsc_pkg::sym_t               in_val_q;
  trsc_pkg::char_t              in_char_q;

  // Result register
  logic                         out_valid_q;
  trsc_pkg::char_t              out_char_q;
  trsc_pkg::char_t              out_char_d;

  // Rotor state
  trsc_pkg::sym_t               off_q [NR];
  trsc_pkg::sym_t               off_d [NR];
  logic                         carry [NR];
  trsc_pkg::sym_t               chain [NR+1];

  logic                         adv;
  logic                         is_load;
  logic                         lower;
  logic                         upper;
  logic                         letter;
  logic                         step;
  logic                         tbl_we;
  trsc_pkg::sym_t               idx0;

  // Advance the input register: loads always retire, characters need room
  assign is_load      = (in_mode_q == trsc_pkg::MODE_LOAD);
  assign adv          = in_valid_q && (is_load || !out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_mode_q <= item_i.mode;
      in_sel_q  <= item_i.rotor_sel;
      in_pos_q  <= item_i.position;
      in_val_q  <= item_i.entry_value;
      in_char_q <= item_i.char_in;
    end
  end

  // Classify the byte and form the letter index
  assign lower  = trsc_pkg::is_lower(in_char_q);
  assign upper  = trsc_pkg::is_upper(in_char_q);
  assign letter = lower || upper;
  assign idx0   = lower ? trsc_pkg::POS_W'(in_char_q - trsc_pkg::CHAR_A_LOWER)
                        : trsc_pkg::POS_W'(in_char_q - trsc_pkg::CHAR_A_UPPER);
  assign chain[0] = idx0;

  assign tbl_we = adv && is_load && (in_pos_q < trsc_pkg::POS_W'(trsc_pkg::ALPHA_LEN));
  assign step   = adv && !is_load && letter;

  // Rotor tables, lookup chain and odometer offsets
  for (genvar r = 0; r < NR; r++) begin : g_rotor
    trsc_pkg::sym_t tbl_q [trsc_pkg::ALPHA_LEN];
    trsc_pkg::sym_t addr;
    trsc_pkg::sym_t entry;

    // Write one table entry on a retiring load whose position is below 26
    always_ff @(posedge clk_i) begin
      if (tbl_we && (int'(in_sel_q) == r)) begin
        tbl_q[in_pos_q] <= in_val_q;
      end
    end

    // Offset the index, look up, fold entries above 25
    assign addr  = trsc_pkg::mod_alpha({1'b0, chain[r]} + {1'b0, off_q[r]});
    assign entry = tbl_q[addr];
    assign chain[r+1] = trsc_pkg::mod_alpha({1'b0, entry});

    // Step the odometer digit and pass on the carry
    if (r == 0) begin : g_first
      assign carry[r] = step;
    end else begin : g_next
      assign carry[r] = carry[r-1] && (off_q[r-1] == trsc_pkg::LAST_COUNT);
    end

    always_comb begin
      off_d[r] = off_q[r];
      if (carry[r]) begin
        off_d[r] = (off_q[r] == trsc_pkg::LAST_COUNT) ? '0 : off_q[r] + 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        off_q[r] <= '0;
      end else begin
        off_q[r] <= off_d[r];
      end
    end
  end

  // Build the result byte
  always_comb begin
    if (!letter) begin
      out_char_d = in_char_q;
    end else if (upper) begin
      out_char_d = trsc_pkg::CHAR_A_UPPER + {3'b000, chain[NR]};
    end else begin
      out_char_d = trsc_pkg::CHAR_A_LOWER + {3'b000, chain[NR]};
    end
  end

  // Result register: fill on a retiring character, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && !is_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !is_load) begin
      out_char_q <= out_char_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.char_out = out_char_q;

`ifndef SYNTHESIS
  // A retiring load into an empty result register gives no result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_load && !out_valid_q) |=> !result_o.valid)
    else $error("load item produced a result");

  // Non-letter bytes pass through unchanged
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !is_load && !letter) |=> (result_o.char_out == $past(in_char_q)))
    else $error("non-letter byte was altered");

  // The first offset only moves when a letter retires
  a_offset_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(off_q[0]))
    else $error("offset stepped without a letter");

  // The first and last offsets stay inside the alphabet
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_q[0] <= trsc_pkg::LAST_COUNT) && (off_q[NR-1] <= trsc_pkg::LAST_COUNT))
    else $error("offset out of range");
`endif

endmodule

`default_nettype wire
